@@ design/tts_pkg.sv @@
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants of the transposition table store
// Table geometry, request and bound codes, slot layout, and the command and
// status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

	// Slot count; a power of two, so the slot is the low key bits.
	localparam int unsigned TABLE_ENTRIES = 16384;
	localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);

	localparam int unsigned KEY_W   = 64;
	localparam int unsigned SCORE_W = 32;
	localparam int unsigned DEPTH_W = 6;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned MOVE_W  = 8;
	localparam int unsigned REQ_W   = 2;

	// Request codes; the fourth code is a no-op with an all-zero result.
	localparam logic [REQ_W-1:0] REQ_PROBE  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_RECORD = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

	// Bound kinds.
	localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_UPPER = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LOWER = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic                      valid;
		logic signed [MOVE_W-1:0]  to;
		logic signed [MOVE_W-1:0]  from;
		logic [KIND_W-1:0]         kind;
		logic [DEPTH_W-1:0]        depth;
		logic signed [SCORE_W-1:0] score;
		logic [KEY_W-1:0]          key;
	} entry_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EVAL,
		ST_CLEAR,
		ST_DONE
	} state_t;

	// Controller -> datapath.
	typedef struct packed {
		logic rd_en;      // accept beat: latch request, read its slot
		logic eval_load;  // evaluate probe/record, write back, load result
		logic sweep_we;   // write an empty slot at the sweep index
		logic done_load;  // load the clear-done result
	} dp_cmd_t;

	// Datapath -> controller.
	typedef struct packed {
		logic sweep_last;
	} dp_sts_t;

endpackage : tts_pkg

`default_nettype wire

@@ design/tts_if.sv @@
// ----------------------------------------------------------------------------
// tts_req_if / tts_rsp_if: request and response channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface tts_req_if;
	logic                valid;
	logic                ready;
	logic [1:0]          req_type;
	logic [63:0]         key;
	logic [5:0]          search_depth;
	logic signed [31:0]  alpha;
	logic signed [31:0]  beta;
	logic signed [31:0]  score;
	logic [1:0]          bound_kind;
	logic signed [7:0]   move_from;
	logic signed [7:0]   move_to;

	modport source (
		output valid, req_type, key, search_depth, alpha, beta, score,
		       bound_kind, move_from, move_to,
		input  ready
	);
	modport sink (
		input  valid, req_type, key, search_depth, alpha, beta, score,
		       bound_kind, move_from, move_to,
		output ready
	);
endinterface : tts_req_if

interface tts_rsp_if;
	logic                valid;
	logic                ready;
	logic                hit;
	logic signed [31:0]  stored_score;
	logic [5:0]          stored_depth;
	logic [1:0]          stored_kind;
	logic signed [7:0]   stored_from;
	logic signed [7:0]   stored_to;
	logic                written;

	modport source (
		output valid, hit, stored_score, stored_depth, stored_kind,
		       stored_from, stored_to, written,
		input  ready
	);
	modport sink (
		input  valid, hit, stored_score, stored_depth, stored_kind,
		       stored_from, stored_to, written,
		output ready
	);
endinterface : tts_rsp_if

`default_nettype wire

@@ design/transposition_table_store_unit.sv @@
// ----------------------------------------------------------------------------
// transposition_table_store_unit: direct-mapped transposition table
// Probe, record and clear requests against a 16384-slot table indexed by the
// low key bits; depth-preferred replacement on a same-key slot.
// ----------------------------------------------------------------------------
// Usage:
//   req : request beats (probe, record, clear, or the no-op code).
//   rsp : exactly one response beat per request beat, in order.
// Timing:
//   Probe/record/no-op: the accept cycle issues the slot read; in ST_EVAL,
//   once the response register is free, the registered read data is
//   compared, a record is written back and the response register loaded.
//   Response appears the cycle after evaluation; no request is accepted
//   during ST_EVAL. Clear: the sweep writes one empty slot per cycle, then
//   the done response (written = 1) is loaded when the register is free.
// Reset:
//   After arst_n releases, the same sweep empties all 16384 slots; req.ready
//   stays low until the sweep is done.
// Backpressure:
//   The response register holds a beat while rsp.ready is low; one further
//   request can be accepted and read meanwhile, then the block waits until
//   the response register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module transposition_table_store_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tts_req_if.sink    req,
	tts_rsp_if.source  rsp
);
	import tts_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer: owns req.ready and rsp.valid.
	tts_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_req_type (req.req_type),
		.in_ready    (req.ready),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.cmd         (cmd),
		.sts         (sts)
	);

	// Table memory, compare and response payload.
	tts_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_req_type     (req.req_type),
		.in_key          (req.key),
		.in_search_depth (req.search_depth),
		.in_alpha        (req.alpha),
		.in_beta         (req.beta),
		.in_score        (req.score),
		.in_bound_kind   (req.bound_kind),
		.in_move_from    (req.move_from),
		.in_move_to      (req.move_to),
		.hit             (rsp.hit),
		.stored_score    (rsp.stored_score),
		.stored_depth    (rsp.stored_depth),
		.stored_kind     (rsp.stored_kind),
		.stored_from     (rsp.stored_from),
		.stored_to       (rsp.stored_to),
		.written         (rsp.written)
	);

endmodule : transposition_table_store_unit

`default_nettype wire

@@ design/tts_ctrl.sv @@
// ----------------------------------------------------------------------------
// tts_ctrl: request sequencer
// Runs the reset sweep, accepts request beats, orders evaluate and clear
// sweeps, and owns the response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic [1:0]            in_req_type,
	output      logic                  in_ready,
	output      logic                  out_valid,
	input  wire logic                  out_ready,
	output      tts_pkg::dp_cmd_t      cmd,
	input  wire tts_pkg::dp_sts_t      sts
);
	import tts_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.eval_load || cmd.done_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep_we = 1'b1;
				if (sts.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.rd_en = 1'b1;
					state_d   = (in_req_type == REQ_CLEAR) ? ST_CLEAR : ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (out_free) begin
					cmd.eval_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				cmd.sweep_we = 1'b1;
				if (sts.sweep_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.done_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule : tts_ctrl

`default_nettype wire

@@ design/tts_datapath.sv @@
// ----------------------------------------------------------------------------
// tts_datapath: slot memory, request registers and hit/replace logic
// One-port-write, one-read slot memory with registered read data, the
// sweep counter, and the response payload registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_datapath (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tts_pkg::dp_cmd_t      cmd,
	output      tts_pkg::dp_sts_t      sts,
	input  wire logic [1:0]            in_req_type,
	input  wire logic [63:0]           in_key,
	input  wire logic [5:0]            in_search_depth,
	input  wire logic signed [31:0]    in_alpha,
	input  wire logic signed [31:0]    in_beta,
	input  wire logic signed [31:0]    in_score,
	input  wire logic [1:0]            in_bound_kind,
	input  wire logic signed [7:0]     in_move_from,
	input  wire logic signed [7:0]     in_move_to,
	output      logic                  hit,
	output      logic signed [31:0]    stored_score,
	output      logic [5:0]            stored_depth,
	output      logic [1:0]            stored_kind,
	output      logic signed [7:0]     stored_from,
	output      logic signed [7:0]     stored_to,
	output      logic                  written
);
	import tts_pkg::*;

	entry_t mem_q [TABLE_ENTRIES];
	entry_t rd_q;

	logic [REQ_W-1:0]          req_type_q;
	logic [KEY_W-1:0]          key_q;
	logic [DEPTH_W-1:0]        depth_q;
	logic signed [SCORE_W-1:0] alpha_q;
	logic signed [SCORE_W-1:0] beta_q;
	logic signed [SCORE_W-1:0] score_q;
	logic [KIND_W-1:0]         kind_q;
	logic signed [MOVE_W-1:0]  from_q;
	logic signed [MOVE_W-1:0]  to_q;

	idx_t   sweep_idx_q;
	idx_t   wr_addr;
	entry_t wr_data;
	logic   wr_en;
	logic   match;
	logic   use_hit;
	logic   keep;
	logic   do_write;

	assign sts.sweep_last = (sweep_idx_q == idx_t'(TABLE_ENTRIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_idx_q <= '0;
		end else if (cmd.sweep_we) begin
			sweep_idx_q <= sts.sweep_last ? '0 : sweep_idx_q + idx_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			req_type_q <= in_req_type;
			key_q      <= in_key;
			depth_q    <= in_search_depth;
			alpha_q    <= in_alpha;
			beta_q     <= in_beta;
			score_q    <= in_score;
			kind_q     <= in_bound_kind;
			from_q     <= in_move_from;
			to_q       <= in_move_to;
		end
	end

	// Hit and replacement decisions on the slot read at the accept beat.
	always_comb begin
		match   = rd_q.valid && (rd_q.key == key_q);
		use_hit = match && ((rd_q.kind == KIND_EXACT) ||
		          (rd_q.kind == KIND_UPPER && rd_q.score <= alpha_q) ||
		          (rd_q.kind == KIND_LOWER && rd_q.score >= beta_q));
		keep     = match && (rd_q.depth > depth_q);
		do_write = (req_type_q == REQ_RECORD) && !keep;
	end

	always_comb begin
		wr_en   = cmd.sweep_we || (cmd.eval_load && do_write);
		wr_addr = cmd.sweep_we ? sweep_idx_q : key_q[IDX_W-1:0];
		wr_data = '0;
		if (!cmd.sweep_we) begin
			wr_data.valid = 1'b1;
			wr_data.to    = to_q;
			wr_data.from  = from_q;
			wr_data.kind  = kind_q;
			wr_data.depth = depth_q;
			wr_data.score = score_q;
			wr_data.key   = key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= mem_q[in_key[IDX_W-1:0]];
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (cmd.eval_load) begin
			if ((req_type_q == REQ_PROBE) && use_hit) begin
				hit          <= 1'b1;
				stored_score <= rd_q.score;
				stored_depth <= rd_q.depth;
				stored_kind  <= rd_q.kind;
				stored_from  <= rd_q.from;
				stored_to    <= rd_q.to;
			end else begin
				hit          <= 1'b0;
				stored_score <= '0;
				stored_depth <= '0;
				stored_kind  <= '0;
				stored_from  <= '0;
				stored_to    <= '0;
			end
			written <= do_write;
		end else if (cmd.done_load) begin
			hit          <= 1'b0;
			stored_score <= '0;
			stored_depth <= '0;
			stored_kind  <= '0;
			stored_from  <= '0;
			stored_to    <= '0;
			written      <= 1'b1;
		end
	end

endmodule : tts_datapath

`default_nettype wire
